// File: src/fpba_pkg.sv
`default_nettype none
package fpba_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam int ADDR_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int LEN_W      = ADDR_BITS + 1;
    localparam int ID_W       = 16;
    localparam int CFG_W      = 17;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_NOID  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] POL_FIRST  = 2'd0;
    localparam logic [1:0] POL_BEST   = 2'd1;
    localparam logic [1:0] POL_WORST  = 2'd2;
    localparam logic [1:0] POL_UNUSED = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_TOTAL_SIZE = 1'b1;

    localparam logic [LEN_W-1:0] REGION_MAX = LEN_W'(1) << ADDR_BITS;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic merge_hi;
        logic merge_lo;
        logic push;
    } fpba_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic merge;
    } fpba_stat_t;

endpackage
`default_nettype wire

// File: src/fpba_ctrl.sv
`default_nettype none
module fpba_ctrl
    import fpba_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire logic       out_free,
    input  wire fpba_stat_t stat,
    output fpba_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_MERGE_HI, S_MERGE_LO, S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
                if (req_valid) state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = stat.merge ? S_MERGE_HI : S_DONE;
            end
            S_MERGE_HI: begin
                cmd.merge_hi = 1'b1;
                state_next   = S_MERGE_LO;
            end
            S_MERGE_LO: begin
                cmd.merge_lo = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                cmd.push = out_free;
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: src/fpba_dp.sv
`default_nettype none
module fpba_dp
    import fpba_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire fpba_cmd_t        cmd,
    output fpba_stat_t            stat,
    input  wire logic             in_kind,
    input  wire logic [LEN_W-1:0] in_req_size,
    input  wire logic [ID_W-1:0]  in_block_id,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    output logic [1:0]            res_status,
    output logic [ID_W-1:0]       res_id,
    output logic [ADDR_BITS-1:0]  res_addr
);

    logic [ADDR_BITS-1:0] start_reg [MAX_BLOCKS];
    logic [LEN_W-1:0]     len_reg   [MAX_BLOCKS];
    logic                 free_reg  [MAX_BLOCKS];
    logic [ID_W-1:0]      owner_reg [MAX_BLOCKS];
    logic [CNT_W-1:0]     count_reg;
    logic [ID_W-1:0]      next_id_reg;
    logic [1:0]           policy_reg;

    logic                 kind_reg;
    logic [LEN_W-1:0]     req_reg;
    logic [ID_W-1:0]      id_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [LEN_W-1:0]     pick_len_reg;
    logic [ADDR_BITS-1:0] pick_start_reg;
    logic                 prev_free_reg;
    logic                 lo_free_reg;
    logic [1:0]           status_reg;
    logic [ID_W-1:0]      rid_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    logic                 e_free;
    logic [LEN_W-1:0]     e_len;
    logic [ID_W-1:0]      e_own;
    logic                 alloc_ok, better, free_ok, split, hi_merge;
    logic [LEN_W-1:0]     init_len;

    assign e_free = free_reg[idx_reg];
    assign e_len  = len_reg[idx_reg];
    assign e_own  = owner_reg[idx_reg];

    assign alloc_ok = (kind_reg == KIND_ALLOC) && e_free && (e_len >= req_reg)
                      && (req_reg != '0) && (policy_reg != POL_UNUSED);
    assign better   = !found_reg
                      || (policy_reg == POL_BEST  && e_len < pick_len_reg)
                      || (policy_reg == POL_WORST && e_len > pick_len_reg);
    assign free_ok  = (kind_reg == KIND_FREE) && !e_free && (e_own == id_reg);
    assign split    = pick_len_reg > req_reg;

    always_comb begin
        hi_merge = 1'b0;
        for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
            if (pick_reg == IDX_W'(k) && CNT_W'(k + 1) < count_reg && free_reg[k + 1])
                hi_merge = 1'b1;
        end
    end

    // region size clamped to 1..2^ADDR_BITS
    always_comb begin
        if (cfg_wdata == '0)
            init_len = LEN_W'(1);
        else if (LEN_W'(cfg_wdata) > REGION_MAX)
            init_len = REGION_MAX;
        else
            init_len = LEN_W'(cfg_wdata);
    end

    assign stat.scan_done = ({1'b0, idx_reg} == count_reg - CNT_W'(1));
    assign stat.merge     = (kind_reg == KIND_FREE) && found_reg;
    assign res_status     = status_reg;
    assign res_id         = rid_reg;
    assign res_addr       = addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            policy_reg   <= POL_FIRST;
            start_reg[0] <= '0;
            len_reg[0]   <= REGION_MAX;
            free_reg[0]  <= 1'b1;
            owner_reg[0] <= '0;
            count_reg    <= CNT_W'(1);
            next_id_reg  <= ID_W'(1);
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_FIT_POLICY) begin
                policy_reg <= cfg_wdata[1:0];
            end else begin
                start_reg[0] <= '0;
                len_reg[0]   <= init_len;
                free_reg[0]  <= 1'b1;
                owner_reg[0] <= '0;
                count_reg    <= CNT_W'(1);
                next_id_reg  <= ID_W'(1);
            end
        end else if (cmd.decide && found_reg) begin
            if (kind_reg == KIND_ALLOC) begin
                if (!(split && count_reg == CNT_W'(MAX_BLOCKS))) begin
                    for (int k = 0; k < MAX_BLOCKS; k++) begin
                        if (split && k >= 2 && IDX_W'(k - 1) > pick_reg) begin
                            start_reg[k] <= start_reg[k - 1];
                            len_reg[k]   <= len_reg[k - 1];
                            free_reg[k]  <= free_reg[k - 1];
                            owner_reg[k] <= owner_reg[k - 1];
                        end else if (split && k >= 1 && IDX_W'(k - 1) == pick_reg) begin
                            start_reg[k] <= pick_start_reg + ADDR_BITS'(req_reg);
                            len_reg[k]   <= pick_len_reg - req_reg;
                            free_reg[k]  <= 1'b1;
                            owner_reg[k] <= '0;
                        end else if (IDX_W'(k) == pick_reg) begin
                            len_reg[k]   <= req_reg;
                            free_reg[k]  <= 1'b0;
                            owner_reg[k] <= next_id_reg;
                        end
                    end
                    if (split) count_reg <= count_reg + CNT_W'(1);
                    next_id_reg <= (next_id_reg == '1) ? ID_W'(1) : next_id_reg + ID_W'(1);
                end
            end else begin
                free_reg[pick_reg]  <= 1'b1;
                owner_reg[pick_reg] <= '0;
            end
        end else if (cmd.merge_hi && hi_merge) begin
            for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
                if (IDX_W'(k) == pick_reg) begin
                    len_reg[k] <= len_reg[k] + len_reg[k + 1];
                end else if (IDX_W'(k) > pick_reg) begin
                    start_reg[k] <= start_reg[k + 1];
                    len_reg[k]   <= len_reg[k + 1];
                    free_reg[k]  <= free_reg[k + 1];
                    owner_reg[k] <= owner_reg[k + 1];
                end
            end
            count_reg <= count_reg - CNT_W'(1);
        end else if (cmd.merge_lo && lo_free_reg) begin
            // block before the freed one absorbs it
            for (int k = 0; k < MAX_BLOCKS - 1; k++) begin
                if (IDX_W'(k + 1) == pick_reg) begin
                    len_reg[k] <= len_reg[k] + len_reg[k + 1];
                end else if (IDX_W'(k) >= pick_reg) begin
                    start_reg[k] <= start_reg[k + 1];
                    len_reg[k]   <= len_reg[k + 1];
                    free_reg[k]  <= free_reg[k + 1];
                    owner_reg[k] <= owner_reg[k + 1];
                end
            end
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg      <= in_kind;
            req_reg       <= in_req_size;
            id_reg        <= in_block_id;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            prev_free_reg <= 1'b0;
            lo_free_reg   <= 1'b0;
        end
        if (cmd.scan) begin
            if (alloc_ok && better) begin
                found_reg      <= 1'b1;
                pick_reg       <= idx_reg;
                pick_len_reg   <= e_len;
                pick_start_reg <= start_reg[idx_reg];
            end else if (free_ok && !found_reg) begin
                found_reg   <= 1'b1;
                pick_reg    <= idx_reg;
                lo_free_reg <= prev_free_reg;
            end
            prev_free_reg <= e_free;
            idx_reg       <= idx_reg + IDX_W'(1);
        end
        if (cmd.decide) begin
            status_reg <= ST_OK;
            rid_reg    <= '0;
            addr_reg   <= '0;
            if (kind_reg == KIND_ALLOC) begin
                if (!found_reg) begin
                    status_reg <= ST_NOFIT;
                end else if (split && count_reg == CNT_W'(MAX_BLOCKS)) begin
                    status_reg <= ST_FULL;
                end else begin
                    rid_reg  <= next_id_reg;
                    addr_reg <= pick_start_reg;
                end
            end else begin
                if (!found_reg) status_reg <= ST_NOID;
                else rid_reg <= id_reg;
            end
        end
    end

endmodule
`default_nettype wire

// File: src/fit_policy_block_allocator.sv
// first, best or worst fit allocator over a table of up to 32 blocks
//
// requests enter on the s_ channel: s_tuser is the kind (0 allocate, 1 free),
// s_tdata carries req_size and block_id. each request gives exactly one result
// on the m_ channel with status, result_id and start_address.
// fit_policy and total_size are set through cfg_wr_en/cfg_index/cfg_wdata, by
// the user only while the block is idle (the block does not enforce this); a
// write of total_size rebuilds the table as one free block and restarts ids at 1.
// steps: take the request, scan each table entry in turn (block_count entries,
// 1 to 32), decide, on a free that finds its block merge high then low, and
// load the result into the output register.
// the table scan walks one entry per cycle, so one request is worked on at a
// time; the next is taken once the result has moved into the output register.
// a stalled receiver holds the result in the output register; the next request
// still runs and waits for that register to drain before its own result goes.
// reset (aresetn low, synchronous) gives first fit, a 65536 unit region, one
// free block and next id 1; no clearing pass is needed.
`default_nettype none
module fit_policy_block_allocator
    import fpba_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // req_size[16:0], block_id[32:17]
    input  wire logic [0:0]  s_tuser,   // kind[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // status[1:0], result_id[17:2], start_address[33:18]
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_wdata
);

    fpba_cmd_t            cmd;
    fpba_stat_t           stat;
    logic                 out_free;
    logic [1:0]           res_status;
    logic [ID_W-1:0]      res_id;
    logic [ADDR_BITS-1:0] res_addr;
    logic                 m_tvalid_reg;
    logic [39:0]          m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    fpba_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .out_free  (out_free),
        .stat      (stat),
        .cmd       (cmd)
    );

    fpba_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_kind     (s_tuser[0]),
        .in_req_size (s_tdata[16:0]),
        .in_block_id (s_tdata[32:17]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .res_status  (res_status),
        .res_id      (res_id),
        .res_addr    (res_addr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_tdata_reg <= {6'b0, res_addr, res_id, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire
